@@ hdl/rgps_pkg.sv @@
`timescale 1ns / 1ps

package rgps_pkg;

  // Default width of the pixel coordinates.
  localparam int CoordBitsDef = 12;

  // Width of the packed colors and of the configuration data.
  localparam int ColorBits = 24;
  localparam int CfgDataBits = 24;
  localparam int CfgIdxBits = 3;

  // Blend weight: 0..256, where 256 stands for one.
  localparam int WeightBits = 9;
  localparam int WeightFrac = 8;
  localparam logic [WeightBits-1:0] WeightOne = 9'd256;

  // Geometry register widths.
  localparam int CenterBits = 13;
  localparam int RadiusBits = 12;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_START_CX  = 3'd0,
    REG_START_CY  = 3'd1,
    REG_START_R   = 3'd2,
    REG_END_CX    = 3'd3,
    REG_END_CY    = 3'd4,
    REG_END_R     = 3'd5,
    REG_START_COL = 3'd6,
    REG_END_COL   = 3'd7
  } cfg_reg_e;

endpackage

@@ hdl/rgps_if.sv @@
`timescale 1ns / 1ps

interface rgps_pix_if #(
  parameter int CoordBits = rgps_pkg::CoordBitsDef
);
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] pixel_x;
  logic [CoordBits-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface rgps_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] chan_low;
  logic [7:0] chan_mid;
  logic [7:0] chan_high;

  modport source (output valid, output chan_low, output chan_mid, output chan_high,
                  input ready);
  modport sink (input valid, input chan_low, input chan_mid, input chan_high,
                output ready);
endinterface

interface rgps_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rgps_pkg::CfgIdxBits-1:0]    index;
  logic [rgps_pkg::CfgDataBits-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/rgps_sqrt_cell.sv @@
`timescale 1ns / 1ps

// One result bit of the square root for both circles.
module rgps_sqrt_cell #(
  parameter int XW = 28,
  parameter int K  = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [XW-1:0] rem_i  [2],
  input  logic [XW-1:0] root_i [2],
  output logic          valid_o,
  input  logic          ready_i,
  output logic [XW-1:0] rem_o  [2],
  output logic [XW-1:0] root_o [2]
);

  localparam logic [XW-1:0] TrialBit = XW'(1) << K;

  logic          valid_q;
  logic [XW-1:0] rem_d  [2];
  logic [XW-1:0] root_d [2];
  logic [XW-1:0] rem_q  [2];
  logic [XW-1:0] root_q [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (rem_i[l] >= (root_i[l] | TrialBit)) begin
        rem_d[l]  = rem_i[l] - (root_i[l] | TrialBit);
        root_d[l] = (root_i[l] >> 1) | TrialBit;
      end else begin
        rem_d[l]  = rem_i[l];
        root_d[l] = root_i[l] >> 1;
      end
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

@@ hdl/rgps_div_cell.sv @@
`timescale 1ns / 1ps

// One quotient bit of the blend weight division.
module rgps_div_cell #(
  parameter int NW = 23,
  parameter int QB = 0
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [NW-1:0]                     rem_i,
  input  logic [NW-1:0]                     den_i,
  input  logic [rgps_pkg::WeightBits-1:0]   quo_i,
  input  logic                              zero_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [NW-1:0]                     rem_o,
  output logic [NW-1:0]                     den_o,
  output logic [rgps_pkg::WeightBits-1:0]   quo_o,
  output logic                              zero_o
);

  logic                            valid_q;
  logic [NW-1:0]                   shifted;
  logic [NW-1:0]                   rem_d;
  logic [rgps_pkg::WeightBits-1:0] quo_d;
  logic [NW-1:0]                   rem_q;
  logic [NW-1:0]                   den_q;
  logic [rgps_pkg::WeightBits-1:0] quo_q;
  logic                            zero_q;

  assign shifted = den_i << QB;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    if (rem_i >= shifted) begin
      rem_d     = rem_i - shifted;
      quo_d[QB] = 1'b1;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      quo_q  <= quo_d;
      zero_q <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign zero_o  = zero_q;

endmodule

@@ hdl/radial_gradient_pixel_shader.sv @@
`timescale 1ns / 1ps

// Two-circle radial gradient shader. The block accepts one pixel coordinate per clock
// while its input is ready and returns one blended RGB triple per pixel, in order, with
// no state kept between pixels. It consists of the row of square root cells (one cell
// per root bit, COORD_BITS + 2 of them for COORD_BITS of 12 and above), the row of nine
// division cells that form the blend weight, and six single register stages: center
// distances, squaring, sum of squares, edge distances, the weighted channel products
// and the final channel sums. Every stage holds its own valid bit and is ready when
// empty or when its successor takes its contents, so bubbles collapse and a stalled
// output does not block acceptance until the pipeline is full. The geometry and
// colors are written through the configuration channel (always ready); the user must
// write them only while no pixel is in flight, which the block does not enforce.
module radial_gradient_pixel_shader #(
  parameter int COORD_BITS = rgps_pkg::CoordBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rgps_pix_if.sink       pix_i,
  rgps_rgb_if.source     rgb_o,
  rgps_cfg_if.sink       cfg_i
);

  // Signed width of a coordinate difference, and sizes that follow from it.
  localparam int DW   = ((COORD_BITS > 12) ? COORD_BITS : 12) + 2;
  localparam int MW   = DW - 1;           // magnitude of a difference
  localparam int XW   = 2 * DW;           // radicand and root working width
  localparam int RW   = DW;               // number of root bits / sqrt cells
  localparam int NW   = RW + 9;           // division working width
  localparam int NQ   = rgps_pkg::WeightBits;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic signed [rgps_pkg::CenterBits-1:0] cx_q [2];
  logic signed [rgps_pkg::CenterBits-1:0] cy_q [2];
  logic        [rgps_pkg::RadiusBits-1:0] rad_q [2];
  logic        [rgps_pkg::ColorBits-1:0]  start_col_q;
  logic        [rgps_pkg::ColorBits-1:0]  end_col_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q        <= '{default: '0};
      cy_q        <= '{default: '0};
      rad_q       <= '{default: '0};
      start_col_q <= '0;
      end_col_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (rgps_pkg::cfg_reg_e'(cfg_i.index))
        rgps_pkg::REG_START_CX:  cx_q[0]     <= cfg_i.data[rgps_pkg::CenterBits-1:0];
        rgps_pkg::REG_START_CY:  cy_q[0]     <= cfg_i.data[rgps_pkg::CenterBits-1:0];
        rgps_pkg::REG_START_R:   rad_q[0]    <= cfg_i.data[rgps_pkg::RadiusBits-1:0];
        rgps_pkg::REG_END_CX:    cx_q[1]     <= cfg_i.data[rgps_pkg::CenterBits-1:0];
        rgps_pkg::REG_END_CY:    cy_q[1]     <= cfg_i.data[rgps_pkg::CenterBits-1:0];
        rgps_pkg::REG_END_R:     rad_q[1]    <= cfg_i.data[rgps_pkg::RadiusBits-1:0];
        rgps_pkg::REG_START_COL: start_col_q <= cfg_i.data[rgps_pkg::ColorBits-1:0];
        rgps_pkg::REG_END_COL:   end_col_q   <= cfg_i.data[rgps_pkg::ColorBits-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshake chain of the single register stages. Each stage loads when it
  // is empty or its successor takes its contents in the same cycle.
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic r1, r2, r3, r4, r5, r6;
  logic sq_ready, sq_valid, dv_ready, dv_valid;

  assign r6 = !v6_q || rgb_o.ready;
  assign r5 = !v5_q || r6;
  assign r4 = !v4_q || dv_ready;
  assign r3 = !v3_q || sq_ready;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign pix_i.ready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (r1) v1_q <= pix_i.valid;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= sq_valid;
      if (r5) v5_q <= dv_valid;
      if (r6) v6_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: distances to both centers, as magnitudes.
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] px_s, py_s;
  logic signed [DW-1:0] dx [2];
  logic signed [DW-1:0] dy [2];
  logic [MW-1:0] adx_q [2];
  logic [MW-1:0] ady_q [2];

  assign px_s = $signed({{(DW-COORD_BITS){1'b0}}, pix_i.pixel_x});
  assign py_s = $signed({{(DW-COORD_BITS){1'b0}}, pix_i.pixel_y});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dx[l] = px_s - DW'(cx_q[l]);
      dy[l] = py_s - DW'(cy_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && pix_i.valid) begin
      for (int l = 0; l < 2; l++) begin
        adx_q[l] <= dx[l][DW-1] ? MW'(-dx[l]) : MW'(dx[l]);
        ady_q[l] <= dy[l][DW-1] ? MW'(-dy[l]) : MW'(dy[l]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: squares. Stage 3: squared distance.
  // ---------------------------------------------------------------------
  logic [2*MW-1:0] sqx_q [2];
  logic [2*MW-1:0] sqy_q [2];
  logic [XW-1:0]   rad2_q [2];

  always_ff @(posedge clk_i) begin
    if (r2 && v1_q) begin
      for (int l = 0; l < 2; l++) begin
        sqx_q[l] <= adx_q[l] * adx_q[l];
        sqy_q[l] <= ady_q[l] * ady_q[l];
      end
    end
    if (r3 && v2_q) begin
      for (int l = 0; l < 2; l++) begin
        rad2_q[l] <= XW'(sqx_q[l]) + XW'(sqy_q[l]);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Square root cells, one root bit each, most significant first.
  // ---------------------------------------------------------------------
  logic          sv  [RW+1];
  logic          sr  [RW+1];
  logic [XW-1:0] srem  [RW+1][2];
  logic [XW-1:0] sroot [RW+1][2];

  assign sv[0]       = v3_q;
  assign sq_ready    = sr[0];
  assign srem[0]     = rad2_q;
  assign sroot[0]    = '{default: '0};
  assign sr[RW]      = r4;
  assign sq_valid    = sv[RW];

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    rgps_sqrt_cell #(
      .XW (XW),
      .K  (2 * (RW - 1 - k))
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sv[k]),
      .ready_o (sr[k]),
      .rem_i   (srem[k]),
      .root_i  (sroot[k]),
      .valid_o (sv[k+1]),
      .ready_i (sr[k+1]),
      .rem_o   (srem[k+1]),
      .root_o  (sroot[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 4: edge distances, their sum, and the scaled dividend.
  // ---------------------------------------------------------------------
  logic [RW-1:0] root_v [2];
  logic [RW-1:0] edge_d [2];
  logic [RW:0]   dsum;
  logic [NW-1:0] num_q, den_q;
  logic          zero_q;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      root_v[l] = sroot[RW][l][RW-1:0];
      if (root_v[l] >= RW'(rad_q[l])) begin
        edge_d[l] = root_v[l] - RW'(rad_q[l]);
      end else begin
        edge_d[l] = RW'(rad_q[l]) - root_v[l];
      end
    end
    dsum = {1'b0, edge_d[0]} + {1'b0, edge_d[1]};
  end

  always_ff @(posedge clk_i) begin
    if (r4 && sq_valid) begin
      num_q  <= {1'b0, edge_d[1], {rgps_pkg::WeightFrac{1'b0}}};
      den_q  <= NW'(dsum);
      zero_q <= (dsum == '0);
    end
  end

  // ---------------------------------------------------------------------
  // Division cells for the weight, one quotient bit each.
  // ---------------------------------------------------------------------
  logic          dvv [NQ+1];
  logic          dvr [NQ+1];
  logic [NW-1:0] drem [NQ+1];
  logic [NW-1:0] dden [NQ+1];
  logic [NQ-1:0] dquo [NQ+1];
  logic          dzero [NQ+1];

  assign dvv[0]   = v4_q;
  assign dv_ready = dvr[0];
  assign drem[0]  = num_q;
  assign dden[0]  = den_q;
  assign dquo[0]  = '0;
  assign dzero[0] = zero_q;
  assign dvr[NQ]  = r5;
  assign dv_valid = dvv[NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_div
    rgps_div_cell #(
      .NW (NW),
      .QB (NQ - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dvv[k]),
      .ready_o (dvr[k]),
      .rem_i   (drem[k]),
      .den_i   (dden[k]),
      .quo_i   (dquo[k]),
      .zero_i  (dzero[k]),
      .valid_o (dvv[k+1]),
      .ready_i (dvr[k+1]),
      .rem_o   (drem[k+1]),
      .den_o   (dden[k+1]),
      .quo_o   (dquo[k+1]),
      .zero_o  (dzero[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 5: weighted channel differences. Stage 6: truncate and add.
  // ---------------------------------------------------------------------
  logic [NQ-1:0]        weight;
  logic signed [8:0]    cdiff [3];
  logic signed [18:0]   prod_q [3];
  logic signed [18:0]   rounded [3];
  logic [7:0]           chan_d [3];
  logic [7:0]           chan_q [3];

  assign weight = dzero[NQ] ? rgps_pkg::WeightOne : dquo[NQ];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cdiff[c] = $signed({1'b0, start_col_q[8*c +: 8]})
               - $signed({1'b0, end_col_q[8*c +: 8]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (r5 && dv_valid) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= $signed({1'b0, weight}) * cdiff[c];
      end
    end
  end

  // Division by 256 toward zero: bias negative products before the shift.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rounded[c] = prod_q[c][18] ? ((prod_q[c] + 19'sd255) >>> rgps_pkg::WeightFrac)
                                 : (prod_q[c] >>> rgps_pkg::WeightFrac);
      chan_d[c]  = end_col_q[8*c +: 8] + rounded[c][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (r6 && v5_q) begin
      chan_q <= chan_d;
    end
  end

  assign rgb_o.valid     = v6_q;
  assign rgb_o.chan_low  = chan_q[0];
  assign rgb_o.chan_mid  = chan_q[1];
  assign rgb_o.chan_high = chan_q[2];

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_weight_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_valid && !dzero[NQ]) |-> (dquo[NQ] <= rgps_pkg::WeightOne))
    else $error("blend weight above one");

  a_low_between : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> ((chan_q[0] >= start_col_q[7:0] && chan_q[0] <= end_col_q[7:0]) ||
              (chan_q[0] <= start_col_q[7:0] && chan_q[0] >= end_col_q[7:0])))
    else $error("low channel outside the color span");

  a_high_between : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> ((chan_q[2] >= start_col_q[23:16] && chan_q[2] <= end_col_q[23:16]) ||
              (chan_q[2] <= start_col_q[23:16] && chan_q[2] >= end_col_q[23:16])))
    else $error("high channel outside the color span");

endmodule

@@ bench/radial_gradient_pixel_shader_test.sv @@
`timescale 1ns / 1ps

// Pixel shading bench: a driver pushes pixel coordinates from a queue in bursts,
// a monitor checks each returned color transfer against a local gradient predictor.
module radial_gradient_pixel_shader_test;

  localparam int CoordBits = rgps_pkg::CoordBitsDef;
  // Number of pipeline cells and register stages in the block; the drain adds a margin.
  localparam int PipeLatency = CoordBits + 17;
  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 200;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
  } pixel_t;

  typedef struct packed {
    logic [7:0] high;
    logic [7:0] mid;
    logic [7:0] low;
  } rgb_t;

  logic clk_i;
  logic rst_ni;

  rgps_pix_if #(.CoordBits(CoordBits)) pix_if ();
  rgps_rgb_if rgb_if ();
  rgps_cfg_if cfg_if ();

  radial_gradient_pixel_shader #(.COORD_BITS(CoordBits)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if.sink),
    .rgb_o  (rgb_if.source),
    .cfg_i  (cfg_if.sink)
  );

  // The predictor keeps its own copy of the geometry and colors.
  longint geo_scx, geo_scy, geo_sr, geo_ecx, geo_ecy, geo_er;
  logic [23:0] col_start, col_end;

  pixel_t pending_pixels[$];
  rgb_t   expected_colors[$];

  int error_count = 0;
  int pixels_sent = 0;
  int colors_seen = 0;
  int cycle_count = 0;
  bit send_paused = 0;
  bit hold_start = 0;
  int hold_off = 0;   // cycles left of a forced long stall of the receiver

  // Directed pixels around the corners of the field for the extreme setup.
  int n_arr[4][2] = '{'{4095, 1}, '{1, 4095}, '{2047, 4095}, '{4095, 2047}};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Floor square root, one root bit per step.
  function automatic longint isqrt(longint val);
    longint bit_v;
    longint root;
    bit_v = 64'sd1 <<< 34;
    root = 0;
    while (bit_v != 0) begin
      if (val >= (root | bit_v)) begin
        val -= (root | bit_v);
        root = (root >>> 1) | bit_v;
      end else begin
        root = root >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return root;
  endfunction

  function automatic longint edge_dist(longint px, longint py, longint cx, longint cy,
                                       longint r);
    longint dx;
    longint dy;
    longint d;
    dx = px - cx;
    dy = py - cy;
    d = isqrt(dx * dx + dy * dy) - r;
    return (d < 0) ? -d : d;
  endfunction

  // The division truncates toward zero, as SystemVerilog does for signed values.
  function automatic logic [7:0] mix_channel(logic [7:0] s, logic [7:0] e, longint w);
    longint diff;
    longint v;
    diff = longint'(s) - longint'(e);
    v = longint'(e) + (w * diff) / 256;
    return v[7:0];
  endfunction

  function automatic rgb_t shade_pixel(pixel_t p);
    longint d1;
    longint d2;
    longint w;
    rgb_t c;
    d1 = edge_dist(p.x, p.y, geo_scx, geo_scy, geo_sr);
    d2 = edge_dist(p.x, p.y, geo_ecx, geo_ecy, geo_er);
    w = (d1 + d2 == 0) ? 256 : (d2 * 256) / (d1 + d2);
    c.low  = mix_channel(col_start[7:0], col_end[7:0], w);
    c.mid  = mix_channel(col_start[15:8], col_end[15:8], w);
    c.high = mix_channel(col_start[23:16], col_end[23:16], w);
    return c;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch on color %0d: %s", colors_seen, what);
    error_count++;
  endtask

  // Writes one register while the block is idle and mirrors it in the predictor.
  task automatic write_reg(rgps_pkg::cfg_reg_e idx, logic [23:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      rgps_pkg::REG_START_CX:  geo_scx = longint'($signed(val[12:0]));
      rgps_pkg::REG_START_CY:  geo_scy = longint'($signed(val[12:0]));
      rgps_pkg::REG_START_R:   geo_sr  = longint'(val[11:0]);
      rgps_pkg::REG_END_CX:    geo_ecx = longint'($signed(val[12:0]));
      rgps_pkg::REG_END_CY:    geo_ecy = longint'($signed(val[12:0]));
      rgps_pkg::REG_END_R:     geo_er  = longint'(val[11:0]);
      rgps_pkg::REG_START_COL: col_start = val;
      rgps_pkg::REG_END_COL:   col_end = val;
      default: ;
    endcase
  endtask

  task automatic write_setup(logic [12:0] scx, logic [12:0] scy, logic [11:0] sr,
                             logic [12:0] ecx, logic [12:0] ecy, logic [11:0] er,
                             logic [23:0] sc, logic [23:0] ec);
    write_reg(rgps_pkg::REG_START_CX, {11'd0, scx});
    write_reg(rgps_pkg::REG_START_CY, {11'd0, scy});
    write_reg(rgps_pkg::REG_START_R, {12'd0, sr});
    write_reg(rgps_pkg::REG_END_CX, {11'd0, ecx});
    write_reg(rgps_pkg::REG_END_CY, {11'd0, ecy});
    write_reg(rgps_pkg::REG_END_R, {12'd0, er});
    write_reg(rgps_pkg::REG_START_COL, sc);
    write_reg(rgps_pkg::REG_END_COL, ec);
  endtask

  task automatic queue_pixel(int x, int y);
    pixel_t p;
    p.x = CoordBits'(x);
    p.y = CoordBits'(y);
    pending_pixels.push_back(p);
  endtask

  // Blocks until every queued pixel is sent and every color has come back, then lets
  // the pipeline settle for its latency. Sampling on the falling edge sees the
  // settled state of the driver and the monitor.
  task automatic drain();
    while (pending_pixels.size() != 0 || pix_if.valid || expected_colors.size() != 0)
      @(negedge clk_i);
    repeat (PipeLatency + 4) @(posedge clk_i);
  endtask

  // Driver: offers pixels in bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid   <= 1'b0;
      pix_if.pixel_x <= '0;
      pix_if.pixel_y <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      // A transfer takes place when valid and ready were both high at this edge.
      if (pix_if.valid && pix_if.ready) begin
        expected_colors.push_back(shade_pixel({pix_if.pixel_x, pix_if.pixel_y}));
        pixels_sent++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (gap_left > 0 || send_paused || pending_pixels.size() == 0) begin
          pix_if.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          pixel_t p;
          p = pending_pixels.pop_front();
          pix_if.valid   <= 1'b1;
          pix_if.pixel_x <= p.x;
          pix_if.pixel_y <= p.y;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            // Many bursts follow each other with no gap at all.
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Receiver hold-off counter: a request starts a long stall that counts down here.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off <= 0;
    end else if (hold_start) begin
      hold_off <= HoldCycles;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: stalls on its own pattern, with long forced hold-offs, and checks each
  // color transfer against the oldest expectation.
  int stall_mode = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_if.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (rgb_if.valid && rgb_if.ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("color transfer with no pixel outstanding");
        end else begin
          rgb_t want;
          want = expected_colors.pop_front();
          if (rgb_if.chan_low !== want.low)
            report_mismatch($sformatf("low got %0d, expected %0d", rgb_if.chan_low,
                                      want.low));
          if (rgb_if.chan_mid !== want.mid)
            report_mismatch($sformatf("mid got %0d, expected %0d", rgb_if.chan_mid,
                                      want.mid));
          if (rgb_if.chan_high !== want.high)
            report_mismatch($sformatf("high got %0d, expected %0d", rgb_if.chan_high,
                                      want.high));
        end
        colors_seen++;
      end
      if (hold_off > 0) begin
        rgb_if.ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
          0: rgb_if.ready <= 1'b1;
          1: rgb_if.ready <= ($urandom_range(0, 3) != 0);
          default: rgb_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[radial_gradient_pixel_shader] ERROR");
      $finish;
    end
  end

  function automatic logic [12:0] rand_center();
    return 13'($urandom_range(0, 8191));
  endfunction

  initial begin
    int n;
    geo_scx = 0; geo_scy = 0; geo_sr = 0;
    geo_ecx = 0; geo_ecy = 0; geo_er = 0;
    col_start = '0; col_end = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = rgps_pkg::REG_START_CX;
    cfg_if.data  = '0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With every register at reset all colors are zero; the origin has both
    // distances zero.
    queue_pixel(0, 0);
    queue_pixel(4095, 4095);
    drain();

    // Both circles centered at the origin with equal radii: pixels on the common
    // edge have both distances zero and take the start color.
    write_setup(13'd0, 13'd0, 12'd5, 13'd0, 13'd0, 12'd5, 24'hFF00A5, 24'h00FF5A);
    queue_pixel(3, 4);
    queue_pixel(5, 0);
    queue_pixel(0, 5);
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    drain();

    // Extreme centers and radii, extreme colors.
    write_setup(13'h1000, 13'h1000, 12'hFFF, 13'h0FFF, 13'h0FFF, 12'd0, 24'hFFFFFF,
                24'h000000);
    foreach (n_arr[i]) queue_pixel(n_arr[i][0], n_arr[i][1]);
    queue_pixel(4095, 4095);
    queue_pixel(0, 0);
    queue_pixel(4095, 0);
    queue_pixel(0, 4095);
    queue_pixel(2048, 2048);
    queue_pixel(1, 1);
    drain();
    write_setup(13'h0FFF, 13'h1000, 12'd0, 13'h1000, 13'h0FFF, 12'hFFF, 24'h000000,
                24'hFFFFFF);
    queue_pixel(4095, 4095);
    queue_pixel(0, 0);
    queue_pixel(1234, 3000);
    queue_pixel(4095, 0);
    drain();

    // Random phases: each draws a geometry, mostly near the pixel field so that
    // edges cross it, then shades a block of random pixels.
    for (int phase = 0; phase < 10; phase++) begin
      if (phase % 3 == 0) begin
        write_setup(rand_center(), rand_center(), 12'($urandom_range(0, 4095)),
                    rand_center(), rand_center(), 12'($urandom_range(0, 4095)),
                    24'($urandom), 24'($urandom));
      end else begin
        write_setup(13'($urandom_range(0, 4095)), 13'($urandom_range(0, 4095)),
                    12'($urandom_range(0, 3000)), 13'($urandom_range(0, 4095)),
                    13'($urandom_range(0, 4095)), 12'($urandom_range(0, 3000)),
                    24'($urandom), 24'($urandom));
      end
      n = 90;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0)
          queue_pixel($urandom_range(0, 15) * 273, $urandom_range(0, 15) * 273);
        else
          queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      // Hold the receiver off for a long stretch so the pipeline fills and
      // back-pressures the pixel input.
      if (phase == 2 || phase == 7) begin
        wait (pix_if.valid);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      // Once, pause the sender mid-phase until every color is back.
      if (phase == 4) begin
        while (pending_pixels.size() > n / 2) @(negedge clk_i);
        send_paused = 1;
        @(negedge clk_i);
        while (pix_if.valid || expected_colors.size() != 0) @(negedge clk_i);
        send_paused = 0;
      end
      drain();
    end

    $display("shaded %0d pixels over the reset state and 13 register setups, %0d colors checked",
             pixels_sent, colors_seen);
    $display("covered coincident edges, extreme centers and radii, long output stalls");
    if (error_count == 0) begin
      $display("[radial_gradient_pixel_shader] OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[radial_gradient_pixel_shader] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/rgps_pkg.sv
hdl/rgps_if.sv
hdl/rgps_sqrt_cell.sv
hdl/rgps_div_cell.sv
hdl/radial_gradient_pixel_shader.sv
bench/radial_gradient_pixel_shader_test.sv
